// ----- rtl/rau_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int DATA_W            = 64;
    localparam int CNT_W             = 7;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_EVAL,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic               undefined_flag;
        logic               overflow_flag;
    } t_out;

endpackage
`default_nettype wire

// ----- rtl/rau_gcd.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rau_gcd (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rau_pkg::DATA_W-1:0]  i_x,
    input  wire logic [rau_pkg::DATA_W-1:0]  i_y,
    output logic                             o_done,
    output logic [rau_pkg::DATA_W-1:0]       o_g
);

    logic                            r_busy;
    logic [rau_pkg::DATA_W-1:0]      r_x;
    logic [rau_pkg::DATA_W-1:0]      r_y;
    logic [rau_pkg::CNT_W-2:0]       r_k;

    assign o_done = r_busy && (r_y == '0);
    assign o_g    = r_x << r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    // Binary GCD: one shift or one subtract per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_k <= '0;
        end else if (r_busy && (r_y != '0)) begin
            if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x > r_y) begin
                r_x <= r_x - r_y;
            end else begin
                r_y <= r_y - r_x;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rau_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rau_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rau_pkg::DATA_W-1:0]  i_dvd,
    input  wire logic [rau_pkg::DATA_W-1:0]  i_dvs,
    output logic                             o_done,
    output logic [rau_pkg::DATA_W-1:0]       o_quo
);

    logic                            r_busy;
    logic [rau_pkg::CNT_W-1:0]       r_cnt;
    logic [rau_pkg::DATA_W-1:0]      r_rem;
    logic [rau_pkg::DATA_W-1:0]      r_quo;
    logic [rau_pkg::DATA_W-1:0]      r_dvs;
    logic [rau_pkg::DATA_W:0]        trial;
    logic                            fits;

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_quo;
    assign trial  = {r_rem, r_quo[rau_pkg::DATA_W-1]};
    assign fits   = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    // Restoring division, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dvd;
            r_dvs <= i_dvs;
            r_cnt <= rau_pkg::CNT_W'(rau_pkg::DATA_W);
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= fits ? rau_pkg::DATA_W'(trial - {1'b0, r_dvs})
                          : trial[rau_pkg::DATA_W-1:0];
            r_quo <= {r_quo[rau_pkg::DATA_W-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rational_arith_unit.sv -----
// Sequence: MUL0, MUL1 and MUL2 on the shared multiplier, then EVAL, then OUT for a zero or
// undefined result; otherwise the binary GCD (one shift or subtract per cycle), then the two
// reducing divisions, numerator first, through one shared restoring divider, then OUT. An
// output stall holds the block in OUT until the output register is free.
// Throughput: one item at a time; the next input transfer can follow once the result sits
// in the output register. Reset: synchronous, active low; the block idles and drops any item.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rau_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output rau_pkg::t_out      o_out
);

    localparam int W  = OPERAND_WIDTH;
    localparam int DW = rau_pkg::DATA_W;

    rau_pkg::t_state r_state, n_state;

    rau_pkg::t_kind     r_kind;
    logic signed [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [DW-1:0] r_p, r_q, r_rd;
    logic [DW-1:0]      r_mn, r_md, r_qn;
    logic               r_neg, r_ovf;
    rau_pkg::t_out      r_res;
    rau_pkg::t_out      r_out;
    logic               r_out_valid;
    logic               out_load;

    logic signed [W-1:0]    mul_a, mul_b;
    logic signed [2*W-1:0]  prod;
    logic signed [DW-1:0]   prod64;
    logic                   bn_zero;

    logic [DW-1:0] s, rn, mn, md;
    logic          same, flip, ovf, neg_n, neg_d, undef;

    logic          gcd_start, gcd_done, div_start, div_done;
    logic [DW-1:0] gcd_g, div_dvd, div_quo;

    assign o_in_ready  = (r_state == rau_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign bn_zero     = (r_bn == '0);
    assign out_load    = (r_state == rau_pkg::ST_OUT) && (!r_out_valid || i_out_ready);

    // Shared multiplier; operands chosen by the sequencer.
    always_comb begin
        mul_a = r_bn;
        mul_b = r_ad;
        case (r_state)
            rau_pkg::ST_MUL0: begin
                mul_a = r_an;
                mul_b = (r_kind == rau_pkg::KIND_MUL ||
                         (r_kind == rau_pkg::KIND_DIV && bn_zero)) ? r_bn : r_bd;
            end
            rau_pkg::ST_MUL1: begin
                mul_a = r_ad;
                mul_b = (r_kind == rau_pkg::KIND_DIV && !bn_zero) ? r_bn : r_bd;
            end
            default: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod64 = DW'(prod);

    always_comb begin
        s     = (r_kind == rau_pkg::KIND_ADD) ? r_p + r_q : r_p - r_q;
        same  = (r_p[DW-1] == r_q[DW-1]);
        flip  = (s[DW-1] != r_p[DW-1]);
        ovf   = 1'b0;
        rn    = r_p;
        neg_n = r_p[DW-1];
        if (r_kind == rau_pkg::KIND_ADD || r_kind == rau_pkg::KIND_SUB) begin
            ovf   = (r_kind == rau_pkg::KIND_ADD) ? (same && flip) : (!same && flip);
            rn    = s;
            neg_n = ovf ? r_p[DW-1] : s[DW-1];
        end
        mn    = neg_n ? ('0 - rn) : rn;
        neg_d = r_rd[DW-1];
        md    = neg_d ? ('0 - r_rd) : r_rd;
        undef = (md == '0);
    end

    assign gcd_start = (r_state == rau_pkg::ST_EVAL) && !undef && (mn != '0);
    assign div_start = ((r_state == rau_pkg::ST_GCD) && gcd_done) ||
                       ((r_state == rau_pkg::ST_DIVN) && div_done);
    assign div_dvd   = (r_state == rau_pkg::ST_GCD) ? r_mn : r_md;

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_x     (mn),
        .i_y     (md),
        .o_done  (gcd_done),
        .o_g     (gcd_g)
    );

    logic [DW-1:0] r_g;

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (div_dvd),
        .i_dvs   ((r_state == rau_pkg::ST_GCD) ? gcd_g : r_g),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            rau_pkg::ST_IDLE: if (i_in_valid) n_state = rau_pkg::ST_MUL0;
            rau_pkg::ST_MUL0: n_state = rau_pkg::ST_MUL1;
            rau_pkg::ST_MUL1: n_state = rau_pkg::ST_MUL2;
            rau_pkg::ST_MUL2: n_state = rau_pkg::ST_EVAL;
            rau_pkg::ST_EVAL: n_state = gcd_start ? rau_pkg::ST_GCD : rau_pkg::ST_OUT;
            rau_pkg::ST_GCD:  if (gcd_done) n_state = rau_pkg::ST_DIVN;
            rau_pkg::ST_DIVN: if (div_done) n_state = rau_pkg::ST_DIVD;
            rau_pkg::ST_DIVD: if (div_done) n_state = rau_pkg::ST_OUT;
            rau_pkg::ST_OUT:  if (out_load) n_state = rau_pkg::ST_IDLE;
            default:          n_state = rau_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rau_pkg::ST_IDLE: begin
                r_kind <= rau_pkg::t_kind'(i_in.kind);
                r_an   <= i_in.a_num[W-1:0];
                r_ad   <= i_in.a_den[W-1:0];
                r_bn   <= i_in.b_num[W-1:0];
                r_bd   <= i_in.b_den[W-1:0];
            end
            rau_pkg::ST_MUL0: r_p  <= prod64;
            rau_pkg::ST_MUL1: r_rd <= prod64;
            rau_pkg::ST_MUL2: r_q  <= prod64;
            rau_pkg::ST_EVAL: begin
                r_mn  <= mn;
                r_md  <= md;
                r_neg <= neg_n ^ neg_d;
                r_ovf <= ovf;
                r_res.overflow_flag  <= ovf;
                r_res.undefined_flag <= undef;
                if (undef) begin
                    r_res.res_num <= rn;
                    r_res.res_den <= '0;
                end else begin
                    r_res.res_num <= '0;
                    r_res.res_den <= 63'd1;
                end
            end
            rau_pkg::ST_GCD: if (gcd_done) r_g <= gcd_g;
            rau_pkg::ST_DIVN: if (div_done) r_qn <= div_quo;
            rau_pkg::ST_DIVD: begin
                if (div_done) begin
                    r_res.res_num <= r_neg ? ('0 - r_qn) : r_qn;
                    r_res.res_den <= div_quo[DW-2:0];
                    r_res.overflow_flag <= r_ovf;
                end
            end
            default: begin
            end
        endcase
    end

    // The output register holds a finished result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
    end

`ifndef SYNTHESIS
    a_undef_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.undefined_flag |-> o_out.res_den == '0)
        else $error("undefined result without zero denominator");
    a_def_nonzero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.undefined_flag |-> o_out.res_den != '0)
        else $error("defined result with zero denominator");
    a_zero_num_unit_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.undefined_flag && o_out.res_num == '0
            |-> o_out.res_den == 63'd1)
        else $error("zero result not normalized to 0/1");
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in work");
`endif

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    rau_pkg::t_in   in_item = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    rau_pkg::t_out  out_item;

    rational_arith_unit uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_item)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    rau_pkg::t_out pending_results[$];
    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   recv_hold = 0;

    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] r;
        while (y != 64'd0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic rau_pkg::t_out reduce_fraction(input rau_pkg::t_in it);
        logic [63:0]   an, ad, bn, bd, rn, rd, p, q, s, mn, md, g, rnum, rden;
        logic          neg_n, neg_d, ovf, same, flip;
        rau_pkg::t_out r;
        an = {{32{it.a_num[31]}}, it.a_num};
        ad = {{32{it.a_den[31]}}, it.a_den};
        bn = {{32{it.b_num[31]}}, it.b_num};
        bd = {{32{it.b_den[31]}}, it.b_den};
        ovf = 1'b0;
        rd = ad * bd;
        if (it.kind == rau_pkg::KIND_ADD || it.kind == rau_pkg::KIND_SUB) begin
            p = an * bd;
            q = bn * ad;
            s = (it.kind == rau_pkg::KIND_ADD) ? p + q : p - q;
            same = (p[63] == q[63]);
            flip = (s[63] != p[63]);
            ovf = (it.kind == rau_pkg::KIND_ADD) ? (same && flip) : (!same && flip);
            rn = s;
            neg_n = ovf ? p[63] : s[63];
            mn = neg_n ? (64'd0 - s) : s;
        end else begin
            rnum = bn;
            rden = bd;
            if (it.kind == rau_pkg::KIND_DIV && bn != 64'd0) begin
                rnum = bd;
                rden = bn;
            end
            rn = an * rnum;
            rd = ad * rden;
            neg_n = rn[63];
            mn = abs64(rn);
        end
        neg_d = rd[63];
        md = abs64(rd);
        r.overflow_flag = ovf;
        r.undefined_flag = (md == 64'd0);
        if (md == 64'd0) begin
            r.res_num = rn;
            r.res_den = '0;
        end else if (mn == 64'd0) begin
            r.res_num = 64'sd0;
            r.res_den = 63'd1;
        end else begin
            g = gcd64(mn, md);
            mn = mn / g;
            md = md / g;
            r.res_num = (neg_n != neg_d) ? (64'd0 - mn) : mn;
            r.res_den = md[62:0];
        end
        return r;
    endfunction

    task automatic offer(input rau_pkg::t_in it, input rau_pkg::t_out want);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results = {pending_results, want};
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result num=%0d den=%0d", $time,
                         out_item.res_num, out_item.res_den);
                errors++;
            end else begin
                rau_pkg::t_out e;
                e = pending_results.pop_front();
                if (e.res_num !== out_item.res_num) begin
                    $display("%0t: res_num expected %0d actual %0d", $time,
                             e.res_num, out_item.res_num);
                    errors++;
                end
                if (e.res_den !== out_item.res_den) begin
                    $display("%0t: res_den expected %0d actual %0d", $time,
                             e.res_den, out_item.res_den);
                    errors++;
                end
                if (e.undefined_flag !== out_item.undefined_flag) begin
                    $display("%0t: undefined_flag expected %b actual %b", $time,
                             e.undefined_flag, out_item.undefined_flag);
                    errors++;
                end
                if (e.overflow_flag !== out_item.overflow_flag) begin
                    $display("%0t: overflow_flag expected %b actual %b", $time,
                             e.overflow_flag, out_item.overflow_flag);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_operand;
        case ($urandom_range(5))
            0: return $urandom_range(15);
            1: return -$urandom_range(15);
            2: return {1'($urandom_range(1)), 31'h7fffffff};
            3: return 32'h80000000 | $urandom_range(3);
            4: return $urandom_range(1000) - 500;
            default: return $urandom;
        endcase
    endfunction

    localparam int DIRECTED_N = 16;
    rau_pkg::t_in directed_items[DIRECTED_N] = '{
        '{rau_pkg::KIND_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3},
        '{rau_pkg::KIND_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd2},
        '{rau_pkg::KIND_MUL, -32'sd2, 32'sd3, 32'sd3, -32'sd4},
        '{rau_pkg::KIND_DIV, 32'sd1, 32'sd2, 32'sd3, 32'sd4},
        '{rau_pkg::KIND_DIV, 32'sd5, 32'sd7, 32'sd0, 32'sd9},
        '{rau_pkg::KIND_DIV, 32'sd5, 32'sd0, 32'sd0, 32'sd9},
        '{rau_pkg::KIND_ADD, 32'sd3, 32'sd0, 32'sd1, 32'sd5},
        '{rau_pkg::KIND_MUL, -32'sd6, -32'sd4, 32'sd1, 32'sd1},
        '{rau_pkg::KIND_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000},
        '{rau_pkg::KIND_ADD, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000},
        '{rau_pkg::KIND_SUB, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000},
        '{rau_pkg::KIND_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff},
        '{rau_pkg::KIND_MUL, 32'h80000000, 32'h1, 32'h80000000, 32'h1},
        '{rau_pkg::KIND_DIV, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff},
        '{rau_pkg::KIND_SUB, 32'sd0, 32'sd7, 32'sd0, -32'sd3},
        '{rau_pkg::KIND_MUL, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff}
    };

    // Rows with a typed-in result; all others go through the predictor.
    bit directed_typed[DIRECTED_N] = '{1, 1, 0, 0, 1, 1, 1, 0, 0, 1, 0, 0, 0, 0, 1, 0};
    rau_pkg::t_out directed_expect[DIRECTED_N] = '{
        '{64'sd5, 63'd6, 1'b0, 1'b0},
        '{64'sd0, 63'd1, 1'b0, 1'b0},
        '0,
        '0,
        '{64'sd0, 63'd1, 1'b0, 1'b0},
        '{64'sd0, 63'd0, 1'b1, 1'b0},
        '{64'sd15, 63'd0, 1'b1, 1'b0},
        '0,
        '0,
        '{64'sd2, 63'd1, 1'b0, 1'b1},
        '0,
        '0,
        '0,
        '0,
        '{64'sd0, 63'd1, 1'b0, 1'b0},
        '0
    };

    initial begin
        rau_pkg::t_in it;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIRECTED_N; i++) begin
            offer(directed_items[i], directed_typed[i] ? directed_expect[i]
                                                       : reduce_fraction(directed_items[i]));
        end
        drain();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                3: begin send_idle_pct = 35; recv_stall_pct = 35; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 327; n++) begin
                if (phase == 4 && n == 10) recv_hold = 1500;
                it.kind = 2'($urandom_range(3));
                it.a_num = rand_operand();
                it.a_den = rand_operand();
                it.b_num = rand_operand();
                it.b_den = rand_operand();
                offer(it, reduce_fraction(it));
            end
            drain();
        end
        repeat (400) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("tb failed");
        $finish;
    end
endmodule

// ----- rational_arith_unit.f -----
rtl/rau_pkg.sv
rtl/rau_gcd.sv
rtl/rau_div.sv
rtl/rational_arith_unit.sv
bench/tb.sv
